>>> rtl/rgbseq_pkg.sv
// ----------------------------------------------------------------------------
// rgbseq_pkg
// Types, codes and pattern tables for the RGB LED event pattern sequencer.
// ----------------------------------------------------------------------------
package rgbseq_pkg;

   localparam int ROM_EVENTS     = 20;
   localparam int ROM_STEPS      = 10;
   localparam int BLINK_STEPS    = 20;
   localparam int BLINK_OFF_MODE = 7;

   localparam logic [2:0] CSR_ADDR_BLINK_MODE = 3'd0;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_ONESHOT = 2'd1,
      CMD_ONGOING = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_FINISH = 2'd1,
      PH_PLAY   = 2'd2
   } phase_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [4:0] event_code;
   } req_type;

   typedef struct packed {
      logic rgb_write;
      logic led_red;
      logic led_green;
      logic led_blue;
      logic status_write;
      logic status_led;
   } rsp_type;

   // red, green, blue masks; bit i is the level at step i
   function automatic logic [29:0] rgb_row(input logic [4:0] ev);
      logic [29:0] row;
      unique case (ev)
         5'd1:    row = {10'h00F, 10'h03C, 10'h0C3};
         5'd2:    row = {10'h155, 10'h155, 10'h000};
         5'd3:    row = {10'h01F, 10'h01F, 10'h000};
         5'd4:    row = {10'h000, 10'h01F, 10'h000};
         5'd5:    row = {10'h000, 10'h0E7, 10'h000};
         5'd6:    row = {10'h000, 10'h155, 10'h000};
         5'd7:    row = {10'h000, 10'h3FF, 10'h000};
         5'd8:    row = {10'h3FF, 10'h01F, 10'h000};
         5'd9:    row = {10'h000, 10'h3FF, 10'h3FF};
         5'd10:   row = {10'h3FF, 10'h000, 10'h3FF};
         5'd11:   row = {10'h01F, 10'h000, 10'h000};
         5'd12:   row = {10'h0E7, 10'h000, 10'h000};
         5'd13:   row = {10'h007, 10'h0E0, 10'h000};
         5'd14:   row = {10'h000, 10'h007, 10'h0E0};
         5'd15:   row = {10'h000, 10'h249, 10'h000};
         5'd16:   row = {10'h333, 10'h0CC, 10'h3FF};
         5'd17:   row = {10'h0CC, 10'h0CC, 10'h333};
         5'd18:   row = {10'h078, 10'h078, 10'h387};
         5'd19:   row = {10'h155, 10'h155, 10'h155};
         default: row = 30'h0;
      endcase
      return row;
   endfunction

   // returns {red, green, blue}
   function automatic logic [2:0] rgb_bits(input logic [4:0] ev, input logic [3:0] step);
      logic [29:0] row;
      logic [2:0]  bits;
      row  = rgb_row(ev);
      bits = 3'b000;
      if (step < 4'(ROM_STEPS)) begin
         bits[2] = row[20 + 32'(step)];
         bits[1] = row[10 + 32'(step)];
         bits[0] = row[32'(step)];
      end
      return bits;
   endfunction

   function automatic logic [19:0] blink_row(input logic [2:0] mode);
      logic [19:0] row;
      unique case (mode)
         3'd0:    row = 20'h07C1F;
         3'd1:    row = 20'h39CE7;
         3'd2:    row = 20'h55555;
         3'd3:    row = 20'h00005;
         3'd4:    row = 20'h00015;
         3'd5:    row = 20'hFFFFF;
         default: row = 20'h00000;
      endcase
      return row;
   endfunction

   function automatic logic blink_bit(input logic [2:0] mode, input logic [4:0] step);
      logic [19:0] row;
      logic        lvl;
      row = blink_row(mode);
      lvl = 1'b0;
      if (step < 5'(BLINK_STEPS)) begin
         lvl = row[step];
      end
      return lvl;
   endfunction

endpackage

>>> rtl/rgb_led_event_pattern_sequencer.sv
// path: an accepted transfer is held in the input register, then its result in the result register
// throughput: one item per cycle while rsp_stall is low; input register and result register are each one stage
// stall on the result side holds the result; one more item waits in the input register
// reset: synchronous, active high; ongoing event 1, no one-time event, steps and mode 0
// ----------------------------------------------------------------------------
// rgb_led_event_pattern_sequencer
// Steps RGB and status LED patterns from constant tables on tick and event
// commands, one result per command.
// ----------------------------------------------------------------------------
module rgb_led_event_pattern_sequencer #(
   parameter int NUM_EVENTS    = 20,
   parameter int PATTERN_STEPS = 10,
   parameter int STATUS_STEPS  = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rgbseq_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rgbseq_pkg::rsp_type rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   logic                  in_valid_ff, in_valid_in;
   rgbseq_pkg::req_type   in_data_ff;
   logic                  out_valid_ff, out_valid_in;
   rgbseq_pkg::rsp_type   out_data_ff, out_data_in;
   logic                  move;
   logic                  accept;

   logic [2:0]            mode_ff, mode_in;
   logic [4:0]            ongoing_ff, ongoing_in;
   logic [4:0]            oneshot_ff, oneshot_in;
   rgbseq_pkg::phase_type phase_ff, phase_in;
   logic [3:0]            pstep_ff, pstep_in;
   logic [4:0]            sstep_ff, sstep_in;

   rgbseq_pkg::cmd_type   cmd;
   logic [4:0]            code;
   logic                  code_ok;
   logic [4:0]            pstep_next;
   logic [5:0]            sstep_next;
   logic                  status_on;

   // handshake
   assign move      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !move;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign in_valid_in  = accept ? 1'b1 : (move ? 1'b0 : in_valid_ff);
   assign out_valid_in = move ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   // configuration
   assign pready  = 1'b1;
   assign prdata  = (paddr == rgbseq_pkg::CSR_ADDR_BLINK_MODE) ? {29'h0, mode_ff} : 32'h0;
   assign mode_in = (psel && penable && pwrite && paddr == rgbseq_pkg::CSR_ADDR_BLINK_MODE)
                    ? pwdata[2:0] : mode_ff;

   // decode
   assign cmd        = rgbseq_pkg::cmd_type'(in_data_ff.cmd);
   assign code       = in_data_ff.event_code;
   assign code_ok    = {1'b0, code} < 6'(NUM_EVENTS);
   assign pstep_next = {1'b0, pstep_ff} + 5'd1;
   assign sstep_next = {1'b0, sstep_ff} + 6'd1;
   assign status_on  = mode_ff < 3'(rgbseq_pkg::BLINK_OFF_MODE);

   // next state
   always_comb begin
      ongoing_in = ongoing_ff;
      oneshot_in = oneshot_ff;
      phase_in   = phase_ff;
      pstep_in   = pstep_ff;
      sstep_in   = sstep_ff;
      if (move) begin
         unique case (cmd)
            rgbseq_pkg::CMD_TICK: begin
               if (oneshot_ff != 5'd0) begin
                  unique case (phase_ff)
                     rgbseq_pkg::PH_START: begin
                        phase_in = rgbseq_pkg::PH_PLAY;
                        pstep_in = 4'd0;
                     end
                     rgbseq_pkg::PH_FINISH: begin
                        phase_in   = rgbseq_pkg::PH_START;
                        oneshot_in = 5'd0;
                        pstep_in   = 4'd0;
                     end
                     rgbseq_pkg::PH_PLAY: begin
                        if (pstep_next >= 5'(PATTERN_STEPS)) begin
                           phase_in = rgbseq_pkg::PH_FINISH;
                        end
                        pstep_in = pstep_next[3:0];
                     end
                     default: ;
                  endcase
               end else begin
                  pstep_in = (pstep_next >= 5'(PATTERN_STEPS)) ? 4'd0 : pstep_next[3:0];
                  if (status_on) begin
                     sstep_in = (sstep_next >= 6'(STATUS_STEPS)) ? 5'd0 : sstep_next[4:0];
                  end
               end
            end
            rgbseq_pkg::CMD_ONESHOT: begin
               if (code_ok) begin
                  phase_in   = rgbseq_pkg::PH_START;
                  oneshot_in = code;
               end
            end
            rgbseq_pkg::CMD_ONGOING: begin
               if (code_ok && code != ongoing_ff) begin
                  ongoing_in = code;
                  pstep_in   = 4'd0;
               end
            end
            default: ;
         endcase
      end
   end

   // result
   always_comb begin
      out_data_in = '0;
      unique case (cmd)
         rgbseq_pkg::CMD_TICK: begin
            if (oneshot_ff != 5'd0) begin
               unique case (phase_ff)
                  rgbseq_pkg::PH_FINISH: begin
                     out_data_in.rgb_write = 1'b1;
                  end
                  rgbseq_pkg::PH_PLAY: begin
                     out_data_in.rgb_write = 1'b1;
                     {out_data_in.led_red, out_data_in.led_green, out_data_in.led_blue} =
                        rgbseq_pkg::rgb_bits(oneshot_ff, pstep_ff);
                  end
                  default: ;
               endcase
            end else begin
               out_data_in.rgb_write = 1'b1;
               {out_data_in.led_red, out_data_in.led_green, out_data_in.led_blue} =
                  rgbseq_pkg::rgb_bits(ongoing_ff, pstep_ff);
               if (status_on) begin
                  out_data_in.status_write = 1'b1;
                  out_data_in.status_led   = rgbseq_pkg::blink_bit(mode_ff, sstep_ff);
               end
            end
         end
         rgbseq_pkg::CMD_ONESHOT: begin
            // restart blanks the rgb outputs
            if (code_ok && oneshot_ff != 5'd0) begin
               out_data_in.rgb_write = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= 3'd0;
         ongoing_ff   <= 5'd1;
         oneshot_ff   <= 5'd0;
         phase_ff     <= rgbseq_pkg::PH_START;
         pstep_ff     <= 4'd0;
         sstep_ff     <= 5'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         mode_ff      <= mode_in;
         ongoing_ff   <= ongoing_in;
         oneshot_ff   <= oneshot_in;
         phase_ff     <= phase_in;
         pstep_ff     <= pstep_in;
         sstep_ff     <= sstep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (move) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule
